>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

>>> rtl/gsdr_pkg.sv
// ----------------------------------------------------------------------------
// gsdr_pkg
// types and constants of the gas sensor divider resistance block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsdr_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned VOLT_W   = 13;
  localparam int unsigned LOAD_W   = 17;
  localparam int unsigned RES_W    = 29;
  localparam int unsigned RATIO_W  = 32;
  localparam int unsigned MUL_W    = 30;
  localparam int unsigned DIV_W    = 45;
  localparam int unsigned STEP_W   = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV            = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_OHMS          = 2'd2;

  localparam logic [COUNT_W-1:0]  SPW_RESET  = 16'd1;
  localparam logic [VOLT_W-1:0]   VREF_RESET = 13'd3300;
  localparam logic [LOAD_W-1:0]   LOAD_RESET = 17'd5000;
  localparam logic [RES_W-1:0]    R0_RESET   = 29'd10000;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;

  localparam logic [STEP_W-1:0] AVG_STEPS   = 6'd28;
  localparam logic [STEP_W-1:0] VOLT_STEPS  = 6'd25;
  localparam logic [STEP_W-1:0] RS_STEPS    = 6'd29;
  localparam logic [STEP_W-1:0] RATIO_STEPS = 6'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_V,
    ST_MUL_R,
    ST_RATIO,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_AVG,
    OP_VOLT,
    OP_RS,
    OP_RATIO
  } op_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                command;
    logic                conversion_failed;
  } in_beat_t;

  typedef struct packed {
    logic                status;
    logic                was_calibration;
    logic [SAMPLE_W-1:0] mean_code;
    logic [VOLT_W-1:0]   voltage_mv;
    logic [RES_W-1:0]    sensor_ohms;
    logic                resistance_open;
    logic [RATIO_W-1:0]  ratio_q16;
    logic                ratio_valid;
    logic                baseline_ok;
  } out_beat_t;

endpackage

>>> rtl/gas_sensor_divider_resistance.sv
// ----------------------------------------------------------------------------
// gas_sensor_divider_resistance
// windowed adc averaging with voltage, divider resistance and rs/r0 ratio
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  in_data_i   (gsdr_pkg::in_beat_t)
//   out      output     out_valid_o/out_ready_i out_data_o (gsdr_pkg::out_beat_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a beat inside a window or a failed conversion is handled directly in the idle state
// a window-closing beat starts up to four divisions on one shared restoring divider,
//   which retires one quotient bit per cycle (28+25+29+45 bits)
// in_ready_o is low outside the idle state or while a result waits unaccepted
// reset is asynchronous, active low; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gas_sensor_divider_resistance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gsdr_pkg::in_beat_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gsdr_pkg::out_beat_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gsdr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gsdr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  gsdr_pkg::state_e state_q, state_d;
  gsdr_pkg::op_e    op_q, op_d;

  logic [gsdr_pkg::COUNT_W-1:0]  spw_q, spw_d;
  logic [gsdr_pkg::VOLT_W-1:0]   vref_q, vref_d;
  logic [gsdr_pkg::LOAD_W-1:0]   load_q, load_d;

  logic [gsdr_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [gsdr_pkg::COUNT_W-1:0]  cnt_q, cnt_d;
  logic                          wcal_q, wcal_d;
  logic [gsdr_pkg::RES_W-1:0]    r0_q, r0_d;
  logic                          bv_q, bv_d;

  logic [gsdr_pkg::DIV_W-1:0]    dvd_q, dvd_d;
  logic [gsdr_pkg::DIV_W-1:0]    quo_q, quo_d;
  logic [gsdr_pkg::RES_W-1:0]    rem_q, rem_d;
  logic [gsdr_pkg::RES_W-1:0]    dsr_q, dsr_d;
  logic [gsdr_pkg::STEP_W-1:0]   step_q, step_d;

  logic [gsdr_pkg::SAMPLE_W-1:0] avg_q, avg_d;
  logic [gsdr_pkg::VOLT_W-1:0]   volt_q, volt_d;
  logic [gsdr_pkg::RES_W-1:0]    rs_q, rs_d;
  logic                          open_q, open_d;
  logic [gsdr_pkg::RATIO_W-1:0]  ratio_q, ratio_d;
  logic                          status_q, status_d;
  logic                          cal_q, cal_d;

  gsdr_pkg::out_beat_t           out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  // shared divider step
  logic [gsdr_pkg::RES_W:0]      trial;
  logic [gsdr_pkg::RES_W:0]      diff;
  logic                          qbit;
  logic [gsdr_pkg::RES_W-1:0]    rem_nx;
  logic [gsdr_pkg::DIV_W-1:0]    quo_nx;

  // shared multiplier
  logic [gsdr_pkg::LOAD_W-1:0]   mul_a;
  logic [gsdr_pkg::VOLT_W-1:0]   mul_b;
  logic [gsdr_pkg::MUL_W-1:0]    mul_p;

  logic                          in_fire;
  logic                          cal_now;
  logic [gsdr_pkg::SUM_W-1:0]    sum_new;
  logic [gsdr_pkg::COUNT_W:0]    cnt_inc;
  logic                          bv_new;
  logic [gsdr_pkg::RES_W-1:0]    r0_new;

  assign trial  = {rem_q, dvd_q[gsdr_pkg::DIV_W-1]};
  assign qbit   = (trial >= {1'b0, dsr_q});
  assign diff   = trial - {1'b0, dsr_q};
  assign rem_nx = qbit ? diff[gsdr_pkg::RES_W-1:0] : trial[gsdr_pkg::RES_W-1:0];
  assign quo_nx = {quo_q[gsdr_pkg::DIV_W-2:0], qbit};

  always_comb begin
    if (state_q == gsdr_pkg::ST_MUL_R) begin
      mul_a = load_q;
      mul_b = {1'b0, gsdr_pkg::FULL_SCALE - avg_q};
    end else begin
      mul_a = {{(gsdr_pkg::LOAD_W-gsdr_pkg::SAMPLE_W){1'b0}}, avg_q};
      mul_b = vref_q;
    end
  end

  assign mul_p = gsdr_pkg::MUL_W'(mul_a) * gsdr_pkg::MUL_W'(mul_b);

  assign in_ready_o  = (state_q == gsdr_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cal_now     = (cnt_q == '0) ? in_data_i.command : wcal_q;
  assign sum_new     = sum_q + gsdr_pkg::SUM_W'(in_data_i.sample);
  assign cnt_inc     = {1'b0, cnt_q} + {{gsdr_pkg::COUNT_W{1'b0}}, 1'b1};
  assign bv_new      = cal_q ? (!open_q && (rs_q != '0)) : bv_q;
  assign r0_new      = cal_q ? rs_q : r0_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    spw_d       = spw_q;
    vref_d      = vref_q;
    load_d      = load_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    wcal_d      = wcal_q;
    r0_d        = r0_q;
    bv_d        = bv_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    step_d      = step_q;
    avg_d       = avg_q;
    volt_d      = volt_q;
    rs_d        = rs_q;
    open_d      = open_q;
    ratio_d     = ratio_q;
    status_d    = status_q;
    cal_d       = cal_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gsdr_pkg::CFG_SAMPLES_PER_WINDOW: spw_d  = cfg_data_i[gsdr_pkg::COUNT_W-1:0];
        gsdr_pkg::CFG_VREF_MV:            vref_d = cfg_data_i[gsdr_pkg::VOLT_W-1:0];
        gsdr_pkg::CFG_LOAD_OHMS:          load_d = cfg_data_i[gsdr_pkg::LOAD_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      gsdr_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.conversion_failed) begin
            sum_d  = '0;
            cnt_d  = '0;
            wcal_d = 1'b0;
            if (cal_now) begin
              bv_d = 1'b0;
            end
            out_d                 = '0;
            out_d.status          = 1'b1;
            out_d.was_calibration = cal_now;
            out_d.baseline_ok     = cal_now ? 1'b0 : bv_q;
            out_valid_d           = 1'b1;
          end else if (cnt_inc >= {1'b0, spw_q}) begin
            // window closes
            sum_d    = '0;
            cnt_d    = '0;
            wcal_d   = 1'b0;
            cal_d    = cal_now;
            status_d = 1'b0;
            open_d   = 1'b0;
            dvd_d    = {sum_new, {(gsdr_pkg::DIV_W-gsdr_pkg::SUM_W){1'b0}}};
            dsr_d    = gsdr_pkg::RES_W'(cnt_inc);
            rem_d    = '0;
            quo_d    = '0;
            step_d   = gsdr_pkg::AVG_STEPS;
            op_d     = gsdr_pkg::OP_AVG;
            state_d  = gsdr_pkg::ST_DIV;
          end else begin
            sum_d  = sum_new;
            cnt_d  = cnt_inc[gsdr_pkg::COUNT_W-1:0];
            wcal_d = cal_now;
          end
        end
      end

      gsdr_pkg::ST_DIV: begin
        dvd_d  = {dvd_q[gsdr_pkg::DIV_W-2:0], 1'b0};
        rem_d  = rem_nx;
        quo_d  = quo_nx;
        step_d = step_q - 1'b1;
        if (step_q == 1) begin
          unique case (op_q)
            gsdr_pkg::OP_AVG: begin
              avg_d   = (quo_nx[gsdr_pkg::SUM_W-1:gsdr_pkg::SAMPLE_W] != '0) ?
                        gsdr_pkg::FULL_SCALE : quo_nx[gsdr_pkg::SAMPLE_W-1:0];
              state_d = gsdr_pkg::ST_MUL_V;
            end
            gsdr_pkg::OP_VOLT: begin
              volt_d  = quo_nx[gsdr_pkg::VOLT_W-1:0];
              state_d = gsdr_pkg::ST_MUL_R;
            end
            gsdr_pkg::OP_RS: begin
              rs_d    = quo_nx[gsdr_pkg::RES_W-1:0];
              state_d = gsdr_pkg::ST_RATIO;
            end
            gsdr_pkg::OP_RATIO: begin
              ratio_d = (quo_nx[gsdr_pkg::DIV_W-1:gsdr_pkg::RATIO_W] != '0) ?
                        '1 : quo_nx[gsdr_pkg::RATIO_W-1:0];
              state_d = gsdr_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
      end

      gsdr_pkg::ST_MUL_V: begin
        // avg * vref / full scale
        dvd_d   = {mul_p[gsdr_pkg::VOLT_STEPS-1:0],
                   {(gsdr_pkg::DIV_W-int'(gsdr_pkg::VOLT_STEPS)){1'b0}}};
        dsr_d   = gsdr_pkg::RES_W'(gsdr_pkg::FULL_SCALE);
        rem_d   = '0;
        quo_d   = '0;
        step_d  = gsdr_pkg::VOLT_STEPS;
        op_d    = gsdr_pkg::OP_VOLT;
        state_d = gsdr_pkg::ST_DIV;
      end

      gsdr_pkg::ST_MUL_R: begin
        open_d = (avg_q == '0);
        if ((avg_q == '0) || (avg_q == gsdr_pkg::FULL_SCALE)) begin
          rs_d    = '0;
          state_d = gsdr_pkg::ST_RATIO;
        end else begin
          // load * (full scale - avg) / avg
          dvd_d   = {mul_p[gsdr_pkg::RES_W-1:0],
                     {(gsdr_pkg::DIV_W-gsdr_pkg::RES_W){1'b0}}};
          dsr_d   = gsdr_pkg::RES_W'(avg_q);
          rem_d   = '0;
          quo_d   = '0;
          step_d  = gsdr_pkg::RS_STEPS;
          op_d    = gsdr_pkg::OP_RS;
          state_d = gsdr_pkg::ST_DIV;
        end
      end

      gsdr_pkg::ST_RATIO: begin
        if (cal_q) begin
          r0_d     = rs_q;
          bv_d     = bv_new;
          status_d = !bv_new;
        end
        if (!bv_new) begin
          ratio_d = '0;
          state_d = gsdr_pkg::ST_DONE;
        end else if (open_q || (r0_new == '0)) begin
          ratio_d = '1;
          state_d = gsdr_pkg::ST_DONE;
        end else begin
          dvd_d   = {rs_q, {(gsdr_pkg::DIV_W-gsdr_pkg::RES_W){1'b0}}};
          dsr_d   = r0_new;
          rem_d   = '0;
          quo_d   = '0;
          step_d  = gsdr_pkg::RATIO_STEPS;
          op_d    = gsdr_pkg::OP_RATIO;
          state_d = gsdr_pkg::ST_DIV;
        end
      end

      gsdr_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status          = status_q;
          out_d.was_calibration = cal_q;
          out_d.mean_code       = avg_q;
          out_d.voltage_mv      = volt_q;
          out_d.sensor_ohms     = rs_q;
          out_d.resistance_open = open_q;
          out_d.ratio_q16       = ratio_q;
          out_d.ratio_valid     = bv_q;
          out_d.baseline_ok     = bv_q;
          out_valid_d           = 1'b1;
          state_d               = gsdr_pkg::ST_IDLE;
        end
      end

      default: state_d = gsdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gsdr_pkg::ST_IDLE;
      op_q        <= gsdr_pkg::OP_AVG;
      spw_q       <= gsdr_pkg::SPW_RESET;
      vref_q      <= gsdr_pkg::VREF_RESET;
      load_q      <= gsdr_pkg::LOAD_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      wcal_q      <= 1'b0;
      r0_q        <= gsdr_pkg::R0_RESET;
      bv_q        <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      spw_q       <= spw_d;
      vref_q      <= vref_d;
      load_q      <= load_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      wcal_q      <= wcal_d;
      r0_q        <= r0_d;
      bv_q        <= bv_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    dsr_q    <= dsr_d;
    avg_q    <= avg_d;
    volt_q   <= volt_d;
    rs_q     <= rs_d;
    open_q   <= open_d;
    ratio_q  <= ratio_d;
    status_q <= status_d;
    cal_q    <= cal_d;
    out_q    <= out_d;
  end

  `ASSERT_PROP(a_div_rem_below_divisor, clk_i, rst_ni,
               (state_q == gsdr_pkg::ST_DIV) |-> (rem_q < dsr_q))
  `ASSERT_PROP(a_div_steps_left, clk_i, rst_ni,
               (state_q == gsdr_pkg::ST_DIV) |-> (step_q != '0))
  `ASSERT_NEVER(a_baseline_zero_r0, clk_i, rst_ni, bv_q && (r0_q == '0))
  `ASSERT_PROP(a_open_result_shape, clk_i, rst_ni,
               (out_valid_q && out_q.resistance_open) |->
               ((out_q.mean_code == '0) && (out_q.sensor_ohms == '0)))
  `ASSERT_PROP(a_ratio_needs_baseline, clk_i, rst_ni,
               (out_valid_q && out_q.ratio_valid) |-> out_q.baseline_ok)

endmodule
